FILE: rtl/core/strong_connectivity_check_core_macros.svh
// Assertion macros for the strong connectivity check core
`ifndef STRONG_CONNECTIVITY_CHECK_CORE_MACROS_SVH
`define STRONG_CONNECTIVITY_CHECK_CORE_MACROS_SVH

// generic clocked assertion with async active-low reset
`define SCC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scc assertion failed");

// default clock and reset of the core
`define SCC_ASSERT(lbl, prop) \
  `SCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/scc_pkg.sv
// Shared types and constants for the strong connectivity check core
`timescale 1ns / 1ps
package scc_pkg;

  localparam int SCC_MAX_VERTICES = 64;
  localparam int SCC_VC_W         = 7;
  localparam int SCC_CNT_MAX      = 127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOADW,
    ST_P1_SCAN,
    ST_EVAL,
    ST_POP,
    ST_P2_SCAN,
    ST_P2_CHK,
    ST_DONE
  } scc_state_e;

  typedef struct packed {
    logic rd;
    logic set;
    logic clr;
  } adj_req_t;

endpackage

FILE: rtl/core/scc_adj_mem.sv
// Adjacency bit matrix memory with per-row valid bits and row bit-set
`timescale 1ns / 1ps
module scc_adj_mem #(
  parameter int N = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scc_pkg::adj_req_t    req_i,
  input  logic [$clog2(N)-1:0] addr_i,
  input  logic [$clog2(N)-1:0] col_i,
  output logic [N-1:0]         row_o
);
  import scc_pkg::*;

  localparam int VW = $clog2(N);

  logic [N-1:0]  mem [N];
  logic [N-1:0]  rdata_q;
  logic          rvld_q;
  logic [N-1:0]  vld_q;
  logic          pend_q;
  logic [VW-1:0] prow_q;
  logic [VW-1:0] pcol_q;

  assign row_o = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem[prow_q] <= row_o | (N'(1) << pcol_q);
    end
    if (req_i.rd) begin
      rdata_q <= mem[addr_i];
    end
    if (req_i.set) begin
      prow_q <= addr_i;
      pcol_q <= col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= req_i.set;
      if (req_i.rd) begin
        rvld_q <= vld_q[addr_i];
      end
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (pend_q) begin
        vld_q[prow_q] <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/scc_stack_mem.sv
// Single-port-write, single-port-read stack memory
`timescale 1ns / 1ps
module scc_stack_mem #(
  parameter int DEPTH = 64,
  parameter int W     = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/core/strong_connectivity_check_core.sv
// Strong connectivity check core: top level
//
// Input channel (in_valid_i / in_stall_o) carries one edge request per item:
// src_vertex_i -> dst_vertex_i when has_edge_i, last_edge_i closes the graph.
// Each request does a row read, then a row write into forward and reverse
// matrices, one memory port each; in_stall_o holds off further requests.
// After the last request the core runs Kosaraju: a forward depth-first pass
// then a reverse pass in reverse finish order. Each search step reads one
// matrix row; each backtrack pops the search stack and reads that row again.
// The result (component_count_o, strongly_connected_o) sits in an output
// register with out_valid_o until out_stall_i is low.
// A receiver stall holds the result; the next result waits for it to drain.
// Matrices clear at once after each graph via valid bits; colors set per search.
// Reset empties the graph and sets vertex count to 1; no clearing pass needed.
// cfg_we_i writes cfg_vertex_count_i; write only while the core is idle.
`timescale 1ns / 1ps
module strong_connectivity_check_core #(
  parameter int MAX_VERTICES = scc_pkg::SCC_MAX_VERTICES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scc_pkg::SCC_VC_W-1:0]  cfg_vertex_count_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [6:0]                    src_vertex_i,
  input  logic [6:0]                    dst_vertex_i,
  input  logic                          has_edge_i,
  input  logic                          last_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          strongly_connected_o,
  output logic [6:0]                    component_count_o
);
  import scc_pkg::*;

  localparam int N  = MAX_VERTICES;
  localparam int VW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int XW = (CW > SCC_VC_W) ? CW : SCC_VC_W;

  scc_state_e state_q, state_d;
  logic          pass_q, pass_d;
  logic          last_q, last_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] fd_q, fd_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] u_q, u_d;
  logic [N-1:0]  white_q, white_d;
  logic [SCC_VC_W-1:0] vc_q;
  logic          out_valid_q, out_valid_d;
  logic          sc_q, sc_d;
  logic [6:0]    cc_q, cc_d;

  adj_req_t      fwd_req, rev_req;
  logic [VW-1:0] fwd_addr, rev_addr, fwd_col, rev_col;
  logic [N-1:0]  fwd_row, rev_row, row, lim, cand;
  logic          s_we, s_re, f_we, f_re;
  logic [VW-1:0] s_waddr, s_raddr, f_waddr, f_raddr;
  logic [VW-1:0] s_rdata, f_rdata, w_idx;
  logic [CW-1:0] fdm1, depm1;
  logic [XW-1:0] src_x, dst_x, srcm1, dstm1, vc_x, cnt_x;
  logic          edge_ok, accept;

  function automatic logic [VW-1:0] lowest_set(input logic [N-1:0] v);
    logic [VW-1:0] r;
    r = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (v[k]) r = VW'(k);
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < N; k++) begin
      lim[k] = (CW'(k) < n_q);
    end
  end

  assign row   = pass_q ? rev_row : fwd_row;
  assign cand  = row & white_q & lim;
  assign w_idx = lowest_set(cand);
  assign fdm1  = fd_q - CW'(1);
  assign depm1 = depth_q - CW'(1);
  assign src_x = XW'(src_vertex_i);
  assign dst_x = XW'(dst_vertex_i);
  assign srcm1 = src_x - XW'(1);
  assign dstm1 = dst_x - XW'(1);
  assign vc_x  = XW'(vc_q);
  assign cnt_x = XW'(cnt_q);
  assign edge_ok = has_edge_i && (src_x != '0) && (src_x <= XW'(N))
                   && (dst_x != '0) && (dst_x <= XW'(N));
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    pass_d = pass_q; last_d = last_q; n_d = n_q; i_d = i_q;
    fd_d = fd_q; depth_d = depth_q; cnt_d = cnt_q; u_d = u_q;
    white_d = white_q;
    out_valid_d = out_valid_q; sc_d = sc_q; cc_d = cc_q;
    fwd_req = '0; rev_req = '0;
    fwd_addr = u_q; rev_addr = u_q;
    fwd_col = dstm1[VW-1:0]; rev_col = srcm1[VW-1:0];
    s_we = 1'b0; s_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
    s_waddr = depth_q[VW-1:0]; s_raddr = depm1[VW-1:0];
    f_waddr = fd_q[VW-1:0];    f_raddr = fdm1[VW-1:0];

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        fwd_addr = srcm1[VW-1:0];
        rev_addr = dstm1[VW-1:0];
        if (accept) begin
          last_d = last_edge_i;
          if (edge_ok) begin
            fwd_req.rd = 1'b1; fwd_req.set = 1'b1;
            rev_req.rd = 1'b1; rev_req.set = 1'b1;
          end
          state_d = ST_LOADW;
        end
      end
      ST_LOADW: begin
        if (last_q) begin
          n_d     = (vc_x > XW'(N)) ? CW'(N) : CW'(vc_x);
          white_d = '1;
          i_d     = '0;
          fd_d    = '0;
          pass_d  = 1'b0;
          state_d = ST_P1_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_P1_SCAN: begin
        if (i_q == n_q) begin
          white_d = '1;
          cnt_d   = '0;
          pass_d  = 1'b1;
          state_d = ST_P2_SCAN;
        end else if (white_q[i_q[VW-1:0]]) begin
          u_d = i_q[VW-1:0];
          white_d[i_q[VW-1:0]] = 1'b0;
          depth_d = '0;
          fwd_addr = i_q[VW-1:0];
          fwd_req.rd = 1'b1;
          state_d = ST_EVAL;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      ST_EVAL: begin
        if (cand != '0) begin
          s_we = 1'b1;
          depth_d = depth_q + CW'(1);
          white_d[w_idx] = 1'b0;
          u_d = w_idx;
          fwd_addr = w_idx; rev_addr = w_idx;
          fwd_req.rd = !pass_q; rev_req.rd = pass_q;
        end else begin
          if (!pass_q) begin
            f_we = 1'b1;
            fd_d = fd_q + CW'(1);
          end
          if (depth_q == '0) begin
            if (!pass_q) begin
              i_d = i_q + CW'(1);
              state_d = ST_P1_SCAN;
            end else begin
              state_d = ST_P2_SCAN;
            end
          end else begin
            s_re = 1'b1;
            depth_d = depm1;
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        u_d = s_rdata;
        fwd_addr = s_rdata; rev_addr = s_rdata;
        fwd_req.rd = !pass_q; rev_req.rd = pass_q;
        state_d = ST_EVAL;
      end
      ST_P2_SCAN: begin
        if (fd_q == '0) begin
          state_d = ST_DONE;
        end else begin
          f_re = 1'b1;
          fd_d = fdm1;
          state_d = ST_P2_CHK;
        end
      end
      ST_P2_CHK: begin
        if (white_q[f_rdata]) begin
          cnt_d = cnt_q + CW'(1);
          white_d[f_rdata] = 1'b0;
          u_d = f_rdata;
          depth_d = '0;
          rev_addr = f_rdata;
          rev_req.rd = 1'b1;
          state_d = ST_EVAL;
        end else begin
          state_d = ST_P2_SCAN;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          sc_d = (cnt_q == CW'(1));
          cc_d = (cnt_x > XW'(SCC_CNT_MAX)) ? 7'(SCC_CNT_MAX) : cnt_x[6:0];
          fwd_req.clr = 1'b1;
          rev_req.clr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      last_q      <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      fd_q        <= '0;
      depth_q     <= '0;
      cnt_q       <= '0;
      u_q         <= '0;
      white_q     <= '0;
      vc_q        <= SCC_VC_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      last_q      <= last_d;
      n_q         <= n_d;
      i_q         <= i_d;
      fd_q        <= fd_d;
      depth_q     <= depth_d;
      cnt_q       <= cnt_d;
      u_q         <= u_d;
      white_q     <= white_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) vc_q <= cfg_vertex_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q <= sc_d;
    cc_q <= cc_d;
  end

  assign out_valid_o          = out_valid_q;
  assign strongly_connected_o = sc_q;
  assign component_count_o    = cc_q;

  scc_adj_mem #(.N(N)) u_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fwd_req),
    .addr_i (fwd_addr),
    .col_i  (fwd_col),
    .row_o  (fwd_row)
  );

  scc_adj_mem #(.N(N)) u_rev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rev_req),
    .addr_i (rev_addr),
    .col_i  (rev_col),
    .row_o  (rev_row)
  );

  scc_stack_mem #(.DEPTH(N), .W(VW)) u_search_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (u_q),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  scc_stack_mem #(.DEPTH(N), .W(VW)) u_finish_stack (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (u_q),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

endmodule

FILE: rtl/core/scc_port_checker.sv
// Port-level assertions for the strong connectivity check core
`timescale 1ns / 1ps
`include "strong_connectivity_check_core_macros.svh"
module scc_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_edge_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       strongly_connected_o,
  input logic [6:0] component_count_o
);
  `SCC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `SCC_ASSERT(a_sc_count, out_valid_o |-> strongly_connected_o == (component_count_o == 7'd1))
  `SCC_ASSERT(a_busy_after_req, in_valid_i && !in_stall_o |=> in_stall_o)
  `SCC_ASSERT(a_no_result_mid, in_valid_i && !in_stall_o && !last_edge_i |=> !$rose(out_valid_o))
endmodule

bind strong_connectivity_check_core scc_port_checker u_port_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .last_edge_i          (last_edge_i),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .strongly_connected_o (strongly_connected_o),
  .component_count_o    (component_count_o)
);
